FILE: hw/rtl/cfsu_pkg.sv
`timescale 1ns / 1ps

package cfsu_pkg;

    localparam int unsigned ID_W    = 11;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERTER_BASE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUX_DEVICE    = 1'b1;

    localparam logic [ID_W-1:0] INVERTER_BASE_RESET = 11'd160;
    localparam logic [ID_W-1:0] AUX_DEVICE_RESET    = 11'd0;

    // id offsets from the inverter base
    localparam logic [ID_W-1:0] LAST_RANGE_OFFSET = 11'h010;
    localparam logic [ID_W-1:0] PARAM_OFFSET      = 11'h022;

    // message slots with their own layout
    localparam logic [SLOT_W-1:0] SLOT_ANALOG = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_BYTES  = 5'd4;
    localparam logic [SLOT_W-1:0] SLOT_STATUS = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_TORQUE = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_DIAG   = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_PARAM  = 5'd17;
    localparam logic [SLOT_W-1:0] SLOT_AUX    = 5'd18;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] data;
    } frame_entry_t;

    // number of signals a message carries
    function automatic logic [POS_W-1:0] num_signals(input logic [SLOT_W-1:0] slot);
        logic [POS_W-1:0] n;
        unique case (slot)
            SLOT_ANALOG: n = 4'd6;
            SLOT_BYTES:  n = 4'd8;
            SLOT_STATUS: n = 4'd11;
            SLOT_TORQUE: n = 4'd3;
            SLOT_DIAG:   n = 4'd2;
            SLOT_PARAM:  n = 4'd3;
            SLOT_AUX:    n = 4'd1;
            default:     n = 4'd4;
        endcase
        return n;
    endfunction

    // value of one signal; byte k of the frame sits in data[8k+7:8k]
    function automatic logic [VALUE_W-1:0] unpack_value(
        input logic [SLOT_W-1:0] slot,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] data
    );
        logic [31:0] lo_word;
        logic [31:0] hi_word;
        logic [VALUE_W-1:0] value;
        lo_word = data[31:0];
        hi_word = data[63:32];
        unique case (slot)
            SLOT_ANALOG: begin
                unique case (pos)
                    4'd0:    value = {22'd0, lo_word[9:0]};
                    4'd1:    value = {22'd0, lo_word[19:10]};
                    4'd2:    value = {22'd0, lo_word[29:20]};
                    4'd3:    value = {22'd0, hi_word[9:0]};
                    4'd4:    value = {22'd0, hi_word[19:10]};
                    4'd5:    value = {22'd0, hi_word[29:20]};
                    default: value = '0;
                endcase
            end
            SLOT_BYTES: begin
                value = {24'd0, data[{pos[2:0], 3'b000} +: 8]};
            end
            SLOT_STATUS: begin
                unique case (pos)
                    4'd0:    value = {16'd0, data[15:0]};
                    4'd1:    value = {24'd0, data[23:16]};
                    4'd2:    value = {24'd0, data[31:24]};
                    4'd3:    value = {31'd0, data[32]};
                    4'd4:    value = {29'd0, data[39:37]};
                    4'd5:    value = {24'd0, data[47:40]};
                    4'd6:    value = {31'd0, data[48]};
                    4'd7:    value = {31'd0, data[55]};
                    4'd8:    value = {31'd0, data[56]};
                    4'd9:    value = {31'd0, data[57]};
                    4'd10:   value = {31'd0, data[58]};
                    default: value = '0;
                endcase
            end
            SLOT_TORQUE: begin
                unique case (pos)
                    4'd0:    value = {16'd0, data[15:0]};
                    4'd1:    value = {16'd0, data[31:16]};
                    4'd2:    value = hi_word;
                    default: value = '0;
                endcase
            end
            SLOT_DIAG: begin
                // big-endian words
                unique case (pos)
                    4'd0:    value = {data[7:0], data[15:8], data[23:16], data[31:24]};
                    4'd1:    value = {data[39:32], data[47:40], data[55:48], data[63:56]};
                    default: value = '0;
                endcase
            end
            SLOT_PARAM: begin
                unique case (pos)
                    4'd0:    value = {16'd0, data[15:0]};
                    4'd1:    value = {24'd0, data[23:16]};
                    4'd2:    value = {16'd0, data[47:32]};
                    default: value = '0;
                endcase
            end
            SLOT_AUX: begin
                value = lo_word;
            end
            default: begin
                value = {16'd0, data[{pos[1:0], 4'b0000} +: 16]};
            end
        endcase
        return value;
    endfunction

endpackage

FILE: hw/rtl/cfsu_front.sv
`timescale 1ns / 1ps

module cfsu_front (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [cfsu_pkg::ID_W-1:0]                frame_id,
    input  logic [7:0]                               byte0,
    input  logic [7:0]                               byte1,
    input  logic [7:0]                               byte2,
    input  logic [7:0]                               byte3,
    input  logic [7:0]                               byte4,
    input  logic [7:0]                               byte5,
    input  logic [7:0]                               byte6,
    input  logic [7:0]                               byte7,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [cfsu_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [cfsu_pkg::ID_W-1:0]                cfg_data,
    input  logic                                     q_full,
    output logic                                     push,
    output cfsu_pkg::frame_entry_t                   push_entry
);

    logic [cfsu_pkg::ID_W-1:0] base_reg;
    logic [cfsu_pkg::ID_W-1:0] base_next;
    logic [cfsu_pkg::ID_W-1:0] aux_reg;
    logic [cfsu_pkg::ID_W-1:0] aux_next;

    logic                          id_ge_base;
    logic [cfsu_pkg::ID_W-1:0]     id_offset;
    logic                          matched;
    logic [cfsu_pkg::SLOT_W-1:0]   slot;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_comb
    begin
        base_next = base_reg;
        aux_next  = aux_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cfsu_pkg::CFG_INVERTER_BASE: base_next = cfg_data;
                cfsu_pkg::CFG_AUX_DEVICE:    aux_next  = cfg_data;
                default:                     base_next = base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= cfsu_pkg::INVERTER_BASE_RESET;
            aux_reg  <= cfsu_pkg::AUX_DEVICE_RESET;
        end
        else
        begin
            base_reg <= base_next;
            aux_reg  <= aux_next;
        end
    end

    // subtraction form keeps base + offset from wrapping
    assign id_ge_base = (frame_id >= base_reg);
    assign id_offset  = frame_id - base_reg;

    always_comb
    begin
        matched = 1'b1;
        slot    = '0;
        priority if (id_ge_base && (id_offset <= cfsu_pkg::LAST_RANGE_OFFSET))
        begin
            slot = id_offset[cfsu_pkg::SLOT_W-1:0];
        end
        else if (id_ge_base && (id_offset == cfsu_pkg::PARAM_OFFSET))
        begin
            slot = cfsu_pkg::SLOT_PARAM;
        end
        else if (frame_id == aux_reg)
        begin
            slot = cfsu_pkg::SLOT_AUX;
        end
        else
        begin
            matched = 1'b0;
        end
    end

    // unmatched frames are taken and dropped
    assign push            = in_valid && !in_stall && matched;
    assign push_entry.slot = slot;
    assign push_entry.data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};

endmodule

FILE: hw/rtl/cfsu_queue.sv
`timescale 1ns / 1ps

module cfsu_queue #(
    parameter int unsigned DEPTH = cfsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cfsu_pkg::frame_entry_t  push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    pop_valid,
    output cfsu_pkg::frame_entry_t  pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cfsu_pkg::frame_entry_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_empty_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

FILE: hw/rtl/cfsu_back.sv
`timescale 1ns / 1ps

module cfsu_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  cfsu_pkg::frame_entry_t               q_entry,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cfsu_pkg::SLOT_W-1:0]          message_slot,
    output logic [cfsu_pkg::POS_W-1:0]           signal_position,
    output logic [cfsu_pkg::VALUE_W-1:0]         signal_value,
    output logic                                 last
);

    logic                              cur_valid_reg;
    logic                              cur_valid_next;
    logic [cfsu_pkg::POS_W-1:0]        pos_reg;
    logic [cfsu_pkg::POS_W-1:0]        pos_next;
    cfsu_pkg::frame_entry_t            cur_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [cfsu_pkg::SLOT_W-1:0]       out_slot_reg;
    logic [cfsu_pkg::POS_W-1:0]        out_pos_reg;
    logic [cfsu_pkg::VALUE_W-1:0]      out_value_reg;
    logic                              out_last_reg;

    logic [cfsu_pkg::POS_W-1:0]        cur_count;
    logic                              cur_last;
    logic                              advance;

    assign cur_count = cfsu_pkg::num_signals(cur_reg.slot);
    assign cur_last  = (pos_reg == cur_count - 1'b1);
    assign advance   = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign q_pop     = q_valid && (!cur_valid_reg || (advance && cur_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            pos_next       = '0;
        end
        else if (advance)
        begin
            cur_valid_next = !cur_last;
            pos_next       = pos_reg + 1'b1;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
        if (advance)
        begin
            out_slot_reg  <= cur_reg.slot;
            out_pos_reg   <= pos_reg;
            out_value_reg <= cfsu_pkg::unpack_value(cur_reg.slot, pos_reg, cur_reg.data);
            out_last_reg  <= cur_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign message_slot    = out_slot_reg;
    assign signal_position = out_pos_reg;
    assign signal_value    = out_value_reg;
    assign last            = out_last_reg;

`ifndef SYNTHESIS
    a_pos_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pos_reg < cur_count))
        else $error("signal position past end of message");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
            (out_pos_reg == cfsu_pkg::num_signals(out_slot_reg) - 1'b1))
        else $error("last flag not on final signal");

    a_next_frame_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && q_pop) |-> (advance && cur_last))
        else $error("frame replaced before all signals sent");
`endif

endmodule

FILE: hw/rtl/can_frame_signal_unpacker_top.sv
`timescale 1ns / 1ps

// CAN frame signal unpacker
// input channel: one beat is a standard frame (frame_id, byte0..byte7), taken
//   when in_valid is high and in_stall is low
// output channel: one beat per unpacked signal (message_slot, signal_position,
//   signal_value, last), taken when out_valid is high and out_stall is low
// config channel: cfg_index 0 writes the inverter base id, 1 the auxiliary
//   device id; cfg_ready is always high
// a frame whose id hits no slot is taken and produces no beat
// path: the first signal of a frame is registered in the queue, then in the
//   back end's frame register, then in the output register before it appears
// throughput: the back end steps through a frame with n signals (1 to 11)
//   with its position counter, one signal per cycle unless the output stalls;
//   frames follow each other with no gap
// the front end accepts a frame every cycle while the frame queue has room
// reset clears the queue, the back end and the output register and loads
//   base id 160 and aux id 0
// when the receiver stalls, the output beat holds, the back end waits, and
//   the front end keeps taking frames until the queue fills, then raises
//   in_stall

module can_frame_signal_unpacker_top #(
    parameter int unsigned QUEUE_DEPTH = cfsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [cfsu_pkg::ID_W-1:0]            frame_id,
    input  logic [7:0]                           byte0,
    input  logic [7:0]                           byte1,
    input  logic [7:0]                           byte2,
    input  logic [7:0]                           byte3,
    input  logic [7:0]                           byte4,
    input  logic [7:0]                           byte5,
    input  logic [7:0]                           byte6,
    input  logic [7:0]                           byte7,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cfsu_pkg::SLOT_W-1:0]          message_slot,
    output logic [cfsu_pkg::POS_W-1:0]           signal_position,
    output logic [cfsu_pkg::VALUE_W-1:0]         signal_value,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cfsu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cfsu_pkg::ID_W-1:0]            cfg_data
);

    // front to queue
    logic                    q_full;
    logic                    push;
    cfsu_pkg::frame_entry_t  push_entry;

    // queue to back
    logic                    q_pop;
    logic                    q_valid;
    cfsu_pkg::frame_entry_t  q_entry;

    // classify: match id against the dictionary, drop misses
    cfsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_id   (frame_id),
        .byte0      (byte0),
        .byte1      (byte1),
        .byte2      (byte2),
        .byte3      (byte3),
        .byte4      (byte4),
        .byte5      (byte5),
        .byte6      (byte6),
        .byte7      (byte7),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // short frame queue decouples classify from emission
    cfsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    // emit: walk the signals of one message, one beat per cycle unless the output stalls
    cfsu_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .message_slot    (message_slot),
        .signal_position (signal_position),
        .signal_value    (signal_value),
        .last            (last)
    );

endmodule
